[hw/rtl/inssort_pkg.sv]
// Shared types and constants of the insertion sorter.
package inssort_pkg;

  localparam int VALUE_W = 32;
  localparam int SHIFT_W = 11;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KEY,
    ST_PREV,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/inssort_if.sv]
// Valid/ready stream interfaces for the element requests and the sorted results.
interface inssort_in_if;
  logic                             valid;
  logic                             ready;
  logic [inssort_pkg::VALUE_W-1:0]  value;
  logic                             last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface inssort_out_if;
  logic                             valid;
  logic                             ready;
  logic [inssort_pkg::VALUE_W-1:0]  sorted_value;
  logic [inssort_pkg::SHIFT_W-1:0]  shift_count;
  logic                             overflow;
  logic                             final_res;

  modport source (output valid, sorted_value, shift_count, overflow, final_res, input ready);
  modport sink   (input valid, sorted_value, shift_count, overflow, final_res, output ready);
endinterface

[hw/rtl/insertion_sorter_with_shift_count.sv]
// Top level of the insertion sorter: loader, sort sequencer and result emitter.
//
// Usage. Elements arrive as requests on din, one per accepted cycle, and the
// request with last set closes the set. Up to DEPTH elements are stored;
// further requests are dropped and the overflow bit of every result of the
// run is set. After the closing request din.ready stays low while the set is
// sorted in place by insertion sort, and then the elements leave on dout in
// ascending order. The last result has final_res set and carries the number
// of element shifts the sort made; shift_count is zero on the others.
// Timing. Each key passes the KEY and PREV steps and then CMP steps until a
// neighbor is not larger or PLACE at position zero, as the store has one read
// port and the single comparator checks one neighbor per cycle. An EMIT_RD
// setup step follows, then one result per cycle while dout.ready is high.
// A stall on dout simply holds the current result; the block takes no new
// element until the final result of the run has been accepted.
// Reset. A synchronous reset returns the block to loading with an empty set,
// a zero shift count and a clear overflow flag. The store needs no clearing.
module insertion_sorter_with_shift_count #(
  parameter int DEPTH = 64
) (
  input logic           clk,
  input logic           rst,
  inssort_in_if.sink    din,
  inssort_out_if.source dout
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  inssort_pkg::state_t state, state_next;

  // Sequencer registers: set size, key index, insertion position, emit index.
  logic [CW-1:0]                   count;
  logic [AW-1:0]                   k;
  logic [AW-1:0]                   pos;
  logic [AW-1:0]                   j;
  logic [inssort_pkg::VALUE_W-1:0] key;
  logic [inssort_pkg::SHIFT_W-1:0] shift;
  logic                            oflow;

  // Element store port controls.
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [inssort_pkg::VALUE_W-1:0] ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [inssort_pkg::VALUE_W-1:0] ram_rdata;

  logic          accept;
  logic          store_ok;
  logic [CW-1:0] count_after;
  logic          greater;
  logic [AW-1:0] pos_m1;
  logic          more_keys;
  logic          fin;

  inssort_ram #(
    .WIDTH (inssort_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept      = din.valid && din.ready;
  assign store_ok    = count < CW'(DEPTH);
  assign count_after = store_ok ? count + CW'(1) : count;
  // The shared comparator: the neighbor just read against the key.
  assign greater     = ram_rdata > key;
  assign pos_m1      = pos - AW'(1);
  assign more_keys   = (CW'(k) + CW'(1)) < count;
  assign fin         = (CW'(j) + CW'(1)) == count;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      inssort_pkg::ST_LOAD: begin
        if (accept && din.last) begin
          // A single element needs no sort.
          state_next = (count_after >= CW'(2)) ? inssort_pkg::ST_KEY
                                               : inssort_pkg::ST_EMIT_RD;
        end
      end
      inssort_pkg::ST_KEY:  state_next = inssort_pkg::ST_PREV;
      inssort_pkg::ST_PREV: state_next = inssort_pkg::ST_CMP;
      inssort_pkg::ST_CMP: begin
        if (greater) begin
          if (pos_m1 == '0) begin
            state_next = inssort_pkg::ST_PLACE;
          end
        end else begin
          state_next = more_keys ? inssort_pkg::ST_KEY : inssort_pkg::ST_EMIT_RD;
        end
      end
      inssort_pkg::ST_PLACE: begin
        state_next = more_keys ? inssort_pkg::ST_KEY : inssort_pkg::ST_EMIT_RD;
      end
      inssort_pkg::ST_EMIT_RD: state_next = inssort_pkg::ST_OUT;
      inssort_pkg::ST_OUT: begin
        if (dout.ready && fin) begin
          state_next = inssort_pkg::ST_LOAD;
        end
      end
      default: state_next = inssort_pkg::ST_LOAD;
    endcase
  end

  // Output logic: handshakes and element store accesses.
  always_comb begin
    din.ready  = 1'b0;
    dout.valid = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = key;
    ram_re     = 1'b0;
    ram_raddr  = pos_m1;
    unique case (state)
      inssort_pkg::ST_LOAD: begin
        din.ready = 1'b1;
        ram_we    = din.valid && store_ok;
        ram_waddr = count[AW-1:0];
        ram_wdata = din.value;
      end
      inssort_pkg::ST_KEY: begin
        ram_re    = 1'b1;
        ram_raddr = k;
      end
      inssort_pkg::ST_PREV: begin
        ram_re    = 1'b1;
        ram_raddr = pos_m1;
      end
      inssort_pkg::ST_CMP: begin
        ram_we = 1'b1;
        if (greater) begin
          // Move the larger neighbor up and fetch the next one down.
          ram_wdata = ram_rdata;
          ram_re    = pos_m1 != '0;
          ram_raddr = pos_m1 - AW'(1);
        end
      end
      inssort_pkg::ST_PLACE: begin
        ram_we = 1'b1;
      end
      inssort_pkg::ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      inssort_pkg::ST_OUT: begin
        dout.valid = 1'b1;
        ram_re     = dout.ready && !fin;
        ram_raddr  = j + AW'(1);
      end
      default: ;
    endcase
  end

  // The read register of the store holds the current result during a stall.
  assign dout.sorted_value = ram_rdata;
  assign dout.shift_count  = fin ? shift : '0;
  assign dout.overflow     = oflow;
  assign dout.final_res    = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= inssort_pkg::ST_LOAD;
      count <= '0;
      shift <= '0;
      oflow <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        inssort_pkg::ST_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              count <= count + CW'(1);
            end else begin
              oflow <= 1'b1;
            end
            if (din.last) begin
              shift <= '0;
              k     <= AW'(1);
            end
          end
        end
        inssort_pkg::ST_KEY: pos <= k;
        inssort_pkg::ST_PREV: key <= ram_rdata;
        inssort_pkg::ST_CMP: begin
          if (greater) begin
            pos <= pos_m1;
            if (shift != inssort_pkg::SHIFT_MAX) begin
              shift <= shift + inssort_pkg::SHIFT_W'(1);
            end
          end else if (more_keys) begin
            k <= k + AW'(1);
          end
        end
        inssort_pkg::ST_PLACE: begin
          if (more_keys) begin
            k <= k + AW'(1);
          end
        end
        inssort_pkg::ST_EMIT_RD: j <= '0;
        inssort_pkg::ST_OUT: begin
          if (dout.ready) begin
            j <= j + AW'(1);
            if (fin) begin
              count <= '0;
              shift <= '0;
              oflow <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(din.ready && dout.valid))
    else $error("input ready while a result is offered");

  // A closing request stops further loading until the run is emitted.
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (accept && din.last) |=> !din.ready)
    else $error("ready after the closing request");

  // The compare step always has a lower neighbor to look at.
  a_cmp_pos: assert property (@(posedge clk) disable iff (rst)
    (state == inssort_pkg::ST_CMP) |-> (pos != '0))
    else $error("compare step at position zero");

  // Accepting the final result leaves an empty set behind.
  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && dout.final_res) |=>
      (count == '0 && shift == '0 && !oflow && din.ready))
    else $error("run state not cleared after the final result");

  // A run in emission always holds at least one element.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (count != '0))
    else $error("result offered from an empty set");

endmodule

[hw/rtl/inssort_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module inssort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
